// ===== rtl/dlpo_pkg.sv =====
// ----------------------------------------------------------------------------
// Dust low pulse occupancy package
// Shared widths, register indexes, constants and sequencer states.
// ----------------------------------------------------------------------------
package dlpo_pkg;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 26;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW    = 2'd0,
      CSR_MIN_PULSE = 2'd1,
      CSR_GAIN      = 2'd2
   } csr_index_type;

   // Field widths.
   localparam int WINDOW_W    = 26;
   localparam int MIN_PULSE_W = 16;
   localparam int GAIN_W      = 16;
   localparam int OCC_OUT_W   = 26;
   localparam int RATIO_W     = 23;
   localparam int PM_W        = 20;

   localparam int COUNT_WIDTH_DEFAULT = 26;

   // Register reset values.
   localparam logic [WINDOW_W-1:0]    WINDOW_RESET    = 26'd30000000;
   localparam logic [MIN_PULSE_W-1:0] MIN_PULSE_RESET = 16'd100;
   localparam logic [GAIN_W-1:0]      GAIN_RESET      = 16'd3277;

   // Output limits.
   localparam logic [OCC_OUT_W-1:0] OCC_OUT_MAX = 26'h3FF_FFFF;
   localparam logic [RATIO_W-1:0]   RATIO_MAX   = 23'd6553600;
   localparam logic [PM_W-1:0]      PM_MAX      = 20'hF_FFFF;

   // Shared multiplier.
   localparam int MUL_A_W = 40;
   localparam int MUL_B_W = 23;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Ratio divider: numerator is occupancy * 100 * 2^16 plus half the window.
   localparam int DIVISOR_W  = WINDOW_W;
   localparam int DIVIDEND_W = DIVISOR_W + RATIO_W;
   localparam int DIV_STEPS  = RATIO_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
   localparam logic [MUL_B_W-1:0] RATIO_SCALE = 23'd100;

   // Cubic, scaled by ten, in Q16.
   localparam int SQ_W  = 30;
   localparam int CUB_W = 37;
   localparam int C10_W = MUL_A_W;
   localparam logic [C10_W-1:0] POLY_CUBIC  = 40'd11;
   localparam logic [C10_W-1:0] POLY_SQUARE = 40'd38;
   localparam logic [C10_W-1:0] POLY_LINEAR = 40'd5200;
   localparam logic [C10_W-1:0] POLY_OFFSET = 40'd406320;

   // Final scaling: (3 * c10 * gain + 2^33) >> 34.
   localparam int PM_SHIFT = 34;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RATIO,
      S_DIV_LOAD,
      S_DIV_RUN,
      S_SQUARE,
      S_CUBE,
      S_POLY_A,
      S_POLY_B,
      S_DIFF,
      S_GAIN,
      S_DONE
   } state_type;

endpackage

// ===== rtl/dlpo_tick.sv =====
// ----------------------------------------------------------------------------
// Dust low pulse occupancy tick tracker
// Times low pulses, sums qualifying pulses and counts the window.
// ----------------------------------------------------------------------------
module dlpo_tick #(
   parameter int COUNT_WIDTH = dlpo_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               tick_en,
   input  logic                               pin_level,
   input  logic [dlpo_pkg::WINDOW_W-1:0]      window_ticks,
   input  logic [dlpo_pkg::MIN_PULSE_W-1:0]   min_pulse_ticks,
   output logic                               window_end,
   output logic [COUNT_WIDTH-1:0]             occ_now
);

   localparam logic [COUNT_WIDTH-1:0] CMAX   = {COUNT_WIDTH{1'b1}};
   localparam logic [32:0]            CMAX_X = 33'(CMAX);

   logic                   in_low_ff, in_low_in;
   logic [COUNT_WIDTH-1:0] len_ff, len_in;
   logic [COUNT_WIDTH-1:0] occ_ff, occ_in;
   logic [COUNT_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [COUNT_WIDTH:0]   occ_sum;
   logic [32:0]            next_cnt;

   always_comb begin
      in_low_in = in_low_ff;
      len_in    = len_ff;
      occ_now   = occ_ff;
      occ_sum   = (COUNT_WIDTH+1)'(occ_ff) + (COUNT_WIDTH+1)'(len_ff);
      if (!pin_level) begin
         in_low_in = 1'b1;
         if (!in_low_ff) begin
            len_in = COUNT_WIDTH'(1);
         end else if (len_ff != CMAX) begin
            len_in = len_ff + COUNT_WIDTH'(1);
         end
      end else if (in_low_ff) begin
         if (len_ff > COUNT_WIDTH'(min_pulse_ticks)) begin
            occ_now = (occ_sum > (COUNT_WIDTH+1)'(CMAX)) ? CMAX : occ_sum[COUNT_WIDTH-1:0];
         end
         in_low_in = 1'b0;
         len_in    = '0;
      end

      // The window check sees the pulse update of the same tick.
      next_cnt   = 33'(elapsed_ff) + 33'd1;
      window_end = !((next_cnt < 33'(window_ticks)) && (next_cnt < CMAX_X));
      occ_in     = window_end ? '0 : occ_now;
      elapsed_in = window_end ? '0 : next_cnt[COUNT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_low_ff  <= 1'b0;
         len_ff     <= '0;
         occ_ff     <= '0;
         elapsed_ff <= '0;
      end else if (tick_en) begin
         in_low_ff  <= in_low_in;
         len_ff     <= len_in;
         occ_ff     <= occ_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

// ===== rtl/dlpo_mul.sv =====
// ----------------------------------------------------------------------------
// Dust low pulse occupancy shared multiplier
// One registered multiplier, loaded on enable and held otherwise.
// ----------------------------------------------------------------------------
module dlpo_mul (
   input  logic                          clock,
   input  logic                          mul_en,
   input  logic [dlpo_pkg::MUL_A_W-1:0]  mul_a,
   input  logic [dlpo_pkg::MUL_B_W-1:0]  mul_b,
   output logic [dlpo_pkg::PROD_W-1:0]   prod
);

   logic [dlpo_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= dlpo_pkg::PROD_W'(mul_a) * dlpo_pkg::PROD_W'(mul_b);
      end
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/dlpo_div.sv =====
// ----------------------------------------------------------------------------
// Dust low pulse occupancy ratio divider
// Restoring divider, one quotient bit per cycle through one compare/subtract.
// ----------------------------------------------------------------------------
module dlpo_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dlpo_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [dlpo_pkg::DIVISOR_W-1:0]    divisor,
   output logic                              done,
   output logic [dlpo_pkg::RATIO_W-1:0]      quotient
);

   logic                               busy_ff;
   logic [dlpo_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic [dlpo_pkg::DIVISOR_W-1:0]     rem_ff;
   logic [dlpo_pkg::RATIO_W-1:0]       num_ff;
   logic [dlpo_pkg::RATIO_W-1:0]       quot_ff;
   logic [dlpo_pkg::DIVISOR_W:0]       trial;
   logic                               fits;

   // The caller guarantees the quotient fits, so the top bits start below the divisor.
   assign trial = {rem_ff, num_ff[dlpo_pkg::RATIO_W-1]};
   assign fits  = trial >= (dlpo_pkg::DIVISOR_W+1)'(divisor);
   assign done  = busy_ff && (cnt_ff == '0);
   assign quotient = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= dlpo_pkg::DIV_CNT_W'(dlpo_pkg::DIV_STEPS);
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - dlpo_pkg::DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= dividend[dlpo_pkg::DIVIDEND_W-1:dlpo_pkg::RATIO_W];
         num_ff  <= dividend[dlpo_pkg::RATIO_W-1:0];
         quot_ff <= '0;
      end else if (busy_ff && (cnt_ff != '0)) begin
         rem_ff  <= fits ? dlpo_pkg::DIVISOR_W'(trial - (dlpo_pkg::DIVISOR_W+1)'(divisor))
                         : trial[dlpo_pkg::DIVISOR_W-1:0];
         num_ff  <= {num_ff[dlpo_pkg::RATIO_W-2:0], 1'b0};
         quot_ff <= {quot_ff[dlpo_pkg::RATIO_W-2:0], fits};
      end
   end

endmodule

// ===== rtl/dust_low_pulse_occupancy.sv =====
// ----------------------------------------------------------------------------
// Dust low pulse occupancy meter
// Low pulse occupancy, low ratio and PM2.5 estimate of a dust sensor pin.
// ----------------------------------------------------------------------------
// Each req_ item is one microsecond tick carrying the sensor pin level.
// The block times each low pulse and, when the pin goes high again, adds
// the pulse length to the window occupancy if it is longer than the
// minimum width. When the window has run its length, one rsp_ item comes
// out with the occupancy, the low ratio in percent (Q7.16) and the PM2.5
// estimate in hundredths of a microgram per cubic meter.
// A tick that does not close a window leaves req_ready high. A tick that
// closes a window starts a sequencer that reuses one registered
// multiplier and a 23-step restoring divider; req_ready stays low until
// the result is loaded into the output register.
// If the receiver stalls, the result waits in the output register and
// further ticks are still taken; only the next window end waits for it.
// The user must write registers on the csr_ channel only while the block is idle;
// the block does not enforce this. Synchronous reset clears the pulse and window
// counters, drops any pending result and restores the register defaults.
// ----------------------------------------------------------------------------
module dust_low_pulse_occupancy #(
   parameter int COUNT_WIDTH = dlpo_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Tick input channel.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_pin_level,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dlpo_pkg::OCC_OUT_W-1:0]      rsp_occupancy_ticks,
   output logic [dlpo_pkg::RATIO_W-1:0]        rsp_ratio_pct,
   output logic [dlpo_pkg::PM_W-1:0]           rsp_pm25_centi,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dlpo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dlpo_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Configuration registers.
   logic [dlpo_pkg::WINDOW_W-1:0]    window_ff;
   logic [dlpo_pkg::MIN_PULSE_W-1:0] min_pulse_ff;
   logic [dlpo_pkg::GAIN_W-1:0]      gain_ff;

   // Sequencer and datapath registers.
   dlpo_pkg::state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0]           occ_snap_ff;
   logic [dlpo_pkg::RATIO_W-1:0]     ratio_ff, ratio_in;
   logic [dlpo_pkg::SQ_W-1:0]        r2_ff, r2_in;
   logic [dlpo_pkg::C10_W-1:0]       acc_ff, acc_in;
   logic [dlpo_pkg::C10_W-1:0]       neg_ff, neg_in;

   // Output register.
   logic                             rsp_valid_ff;
   logic [dlpo_pkg::OCC_OUT_W-1:0]   rsp_occ_ff;
   logic [dlpo_pkg::RATIO_W-1:0]     rsp_ratio_ff;
   logic [dlpo_pkg::PM_W-1:0]        rsp_pm_ff;
   logic                             rsp_load;

   logic                             tick_en;
   logic                             window_end;
   logic [COUNT_WIDTH-1:0]           occ_now;

   logic                             mul_en;
   logic [dlpo_pkg::MUL_A_W-1:0]     mul_a;
   logic [dlpo_pkg::MUL_B_W-1:0]     mul_b;
   logic [dlpo_pkg::PROD_W-1:0]      prod;

   logic                             div_start;
   logic [dlpo_pkg::DIVIDEND_W-1:0]  dividend;
   logic                             div_done;
   logic [dlpo_pkg::RATIO_W-1:0]     div_quot;

   logic [dlpo_pkg::WINDOW_W-1:0]    w_eff;
   logic [31:0]                      occ_ext;
   logic [63:0]                      pm_round;
   logic [63:0]                      pm_full;
   logic [dlpo_pkg::PM_W-1:0]        pm_sat;
   logic [dlpo_pkg::OCC_OUT_W-1:0]   occ_out;

   // ------------------------------------------------------------------------
   // Configuration port. Writes to an unused index are taken and dropped.
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= dlpo_pkg::WINDOW_RESET;
         min_pulse_ff <= dlpo_pkg::MIN_PULSE_RESET;
         gain_ff      <= dlpo_pkg::GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dlpo_pkg::CSR_WINDOW:    window_ff    <= csr_wdata[dlpo_pkg::WINDOW_W-1:0];
            dlpo_pkg::CSR_MIN_PULSE: min_pulse_ff <= csr_wdata[dlpo_pkg::MIN_PULSE_W-1:0];
            dlpo_pkg::CSR_GAIN:      gain_ff      <= csr_wdata[dlpo_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pulse timing and window counting; ticks are taken only while the sequencer is idle.
   // ------------------------------------------------------------------------
   assign req_ready = (state_ff == dlpo_pkg::S_IDLE);
   assign tick_en   = req_valid && req_ready;

   dlpo_tick #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_tick (
      .clock           (clock),
      .reset           (reset),
      .tick_en         (tick_en),
      .pin_level       (req_pin_level),
      .window_ticks    (window_ff),
      .min_pulse_ticks (min_pulse_ff),
      .window_end      (window_end),
      .occ_now         (occ_now)
   );

   dlpo_mul u_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod   (prod)
   );

   dlpo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (w_eff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // A zero window length behaves as one tick.
   assign w_eff   = (window_ff == '0) ? dlpo_pkg::WINDOW_W'(1) : window_ff;
   assign occ_ext = 32'(occ_snap_ff);

   // Numerator of the ratio: occupancy * 100 in Q16, plus half the window for rounding.
   assign dividend = {prod[32:0], 16'b0} + dlpo_pkg::DIVIDEND_W'(w_eff >> 1);

   // Final rounding and PM2.5 clamp from the registered gain product, and the occupancy clamp.
   assign pm_round = 64'(prod) + (64'd1 << (dlpo_pkg::PM_SHIFT - 1));
   assign pm_full  = pm_round >> dlpo_pkg::PM_SHIFT;
   assign pm_sat   = (pm_full > 64'(dlpo_pkg::PM_MAX)) ? dlpo_pkg::PM_MAX
                                                      : pm_full[dlpo_pkg::PM_W-1:0];
   assign occ_out  = (occ_ext > 32'(dlpo_pkg::OCC_OUT_MAX)) ? dlpo_pkg::OCC_OUT_MAX
                                                           : occ_ext[dlpo_pkg::OCC_OUT_W-1:0];

   // ------------------------------------------------------------------------
   // Result sequencer. Its steps load the shared multiplier or the divider, fold the
   // products and the linear term into the cubic, floor it and load the output register.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      ratio_in  = ratio_ff;
      r2_in     = r2_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      rsp_load  = 1'b0;

      unique case (state_ff)
         dlpo_pkg::S_IDLE: begin
            if (tick_en && window_end) begin
               state_in = dlpo_pkg::S_RATIO;
            end
         end
         dlpo_pkg::S_RATIO: begin
            // An occupancy of at least the window length saturates the ratio.
            if (occ_ext >= 32'(w_eff)) begin
               ratio_in = dlpo_pkg::RATIO_MAX;
               state_in = dlpo_pkg::S_SQUARE;
            end else begin
               mul_en   = 1'b1;
               mul_a    = dlpo_pkg::MUL_A_W'(occ_ext[dlpo_pkg::WINDOW_W-1:0]);
               mul_b    = dlpo_pkg::RATIO_SCALE;
               state_in = dlpo_pkg::S_DIV_LOAD;
            end
         end
         dlpo_pkg::S_DIV_LOAD: begin
            div_start = 1'b1;
            state_in  = dlpo_pkg::S_DIV_RUN;
         end
         dlpo_pkg::S_DIV_RUN: begin
            if (div_done) begin
               ratio_in = div_quot;
               state_in = dlpo_pkg::S_SQUARE;
            end
         end
         dlpo_pkg::S_SQUARE: begin
            mul_en   = 1'b1;
            mul_a    = dlpo_pkg::MUL_A_W'(ratio_ff);
            mul_b    = ratio_ff;
            state_in = dlpo_pkg::S_CUBE;
         end
         dlpo_pkg::S_CUBE: begin
            r2_in    = prod[dlpo_pkg::SQ_W+15:16];
            mul_en   = 1'b1;
            mul_a    = dlpo_pkg::MUL_A_W'(prod[dlpo_pkg::SQ_W+15:16]);
            mul_b    = ratio_ff;
            state_in = dlpo_pkg::S_POLY_A;
         end
         dlpo_pkg::S_POLY_A: begin
            acc_in   = dlpo_pkg::C10_W'(prod[dlpo_pkg::CUB_W+15:16]) * dlpo_pkg::POLY_CUBIC
                       + dlpo_pkg::POLY_OFFSET;
            neg_in   = dlpo_pkg::C10_W'(r2_ff) * dlpo_pkg::POLY_SQUARE;
            state_in = dlpo_pkg::S_POLY_B;
         end
         dlpo_pkg::S_POLY_B: begin
            acc_in   = acc_ff + dlpo_pkg::C10_W'(ratio_ff) * dlpo_pkg::POLY_LINEAR;
            state_in = dlpo_pkg::S_DIFF;
         end
         dlpo_pkg::S_DIFF: begin
            // The cubic is floored at zero.
            acc_in   = (acc_ff > neg_ff) ? (acc_ff - neg_ff) : '0;
            state_in = dlpo_pkg::S_GAIN;
         end
         dlpo_pkg::S_GAIN: begin
            mul_en   = 1'b1;
            mul_a    = acc_ff;
            mul_b    = dlpo_pkg::MUL_B_W'(gain_ff) + (dlpo_pkg::MUL_B_W'(gain_ff) << 1);
            state_in = dlpo_pkg::S_DONE;
         end
         dlpo_pkg::S_DONE: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = dlpo_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dlpo_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dlpo_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_en && window_end) begin
         occ_snap_ff <= occ_now;
      end
      ratio_ff <= ratio_in;
      r2_ff    <= r2_in;
      acc_ff   <= acc_in;
      neg_ff   <= neg_in;
   end

   // ------------------------------------------------------------------------
   // Output register.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_occ_ff   <= occ_out;
         rsp_ratio_ff <= ratio_ff;
         rsp_pm_ff    <= pm_sat;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_occupancy_ticks = rsp_occ_ff;
   assign rsp_ratio_pct       = rsp_ratio_ff;
   assign rsp_pm25_centi      = rsp_pm_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_ratio_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ratio_ff <= dlpo_pkg::RATIO_MAX))
      else $error("ratio above 100 percent");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == dlpo_pkg::S_DIV_RUN))
      else $error("divider finished outside its wait state");

   a_plain_tick: assert property (@(posedge clock) disable iff (reset)
      (tick_en && !window_end) |=> (state_ff == dlpo_pkg::S_IDLE))
      else $error("tick inside a window started the result sequencer");

   a_window_start: assert property (@(posedge clock) disable iff (reset)
      (tick_en && window_end) |=> (state_ff == dlpo_pkg::S_RATIO))
      else $error("window end did not start the result sequencer");

endmodule
